// ===== rtl/core/swrs_pkg.sv =====
// ============================================================================
// swrs_pkg - shared types and helpers for the sliding-window slope block
// Holds the sequencer states, the wide-multiply operation codes, the divider
// request bundle and the limb selector used by the shared multiplier.
// ============================================================================
`default_nettype none

package swrs_pkg;

    // Width of the divider step count (the longest division is under 256 steps).
    localparam int DIV_STEP_W = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OLD,
        ST_UPD,
        ST_RD,
        ST_SQ,
        ST_XY,
        ST_ACC,
        ST_WM_MUL,
        ST_WM_ACC,
        ST_SLOPE_GO,
        ST_SLOPE_WAIT,
        ST_TMEAN_GO,
        ST_TMEAN_WAIT,
        ST_FMEAN_GO,
        ST_FMEAN_WAIT,
        ST_OUT
    } state_t;

    // Wide products built from 32-bit limbs, in the order they are run.
    typedef enum logic [1:0] {
        OP_N_SXY,
        OP_SX_SY,
        OP_N_SXX,
        OP_SX_SX
    } op_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_STEP_W-1:0] steps;
    } div_req_t;

    // Splits a 96-bit two's complement word into two unsigned limbs and one
    // signed top limb, each returned as a 33-bit signed multiplier operand.
    function automatic logic signed [32:0] limb_sel(input logic [95:0] v,
                                                    input logic [1:0]  idx);
        logic signed [32:0] r;
        case (idx)
            2'd0:    r = {1'b0, v[31:0]};
            2'd1:    r = {1'b0, v[63:32]};
            default: r = {v[95], v[95:64]};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sliding_window_regression_slope_top.sv =====
// ============================================================================
// sliding_window_regression_slope_top - windowed least-squares slope and means
// Keeps the last WINDOW samples and, for each new one, returns the slope of
// temperature against time plus the mean temperature and mean flux.
// ============================================================================
//
//  Channel   Direction  Signals                      Content
//  s_*       in         s_tvalid s_tready s_tdata    sample request
//  m_*       out        m_tvalid m_tready m_tdata    slope and means
//                       m_tuser                      degenerate-slope flag
//
// The time one request takes grows with n, the held sample count, and is set
// by the shared multiplier (a walk over the held samples, then four wide
// products of nine limb products each) and by the bit-serial divider (one
// slope and two mean divisions). s_tready is high only while the sequencer
// is idle. A finished result sits in the output register, so the next
// request is taken while the previous result still waits. Reset clears the
// fill count, ring pointer, running sums and all control state; the sample
// memory is left as is, since only written entries are ever read.
//
`default_nettype none

module sliding_window_regression_slope_top #(
    parameter int WINDOW = 5
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // sample_time, temp_sample, flux_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // temp_slope, temp_mean, flux_mean
    output logic             m_tuser    // slope_degenerate
);
    import swrs_pkg::*;

    // Count and address widths, then the exact widths of the running sums.
    localparam int CW   = $clog2(WINDOW + 1);
    localparam int AW   = $clog2(WINDOW);
    localparam int SUMW = 32 + CW;
    localparam int SQW  = 64 + CW;
    localparam int XYW  = 65 + CW;
    localparam int DENW = 66 + 2 * CW;
    localparam int NUMW = DENW + 1;
    localparam int DIVW = DENW + 16;

    state_t state_reg, state_next;

    // Sample held from the accepted request.
    logic [95:0] smp_reg, smp_next;

    // Ring bookkeeping.
    logic [CW-1:0] fill_reg, fill_next;
    logic [AW-1:0] oldest_reg, oldest_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] k_reg, k_next;

    logic signed [SUMW-1:0] tsum_reg, tsum_next;
    logic signed [SUMW-1:0] fsum_reg, fsum_next;

    // Window sums built during the walk.
    logic [SUMW-1:0]        sx_reg, sx_next;
    logic signed [SUMW-1:0] sy_reg, sy_next;
    logic [SQW-1:0]         sxx_reg, sxx_next;
    logic signed [XYW-1:0]  sxy_reg, sxy_next;

    // Wide product accumulation.
    logic [127:0]      acc_reg, acc_next;
    op_t               op_reg, op_next;
    logic [1:0]        li_reg, li_next;
    logic [1:0]        lj_reg, lj_next;
    logic [NUMW-1:0]   num_reg, num_next;
    logic [DENW-1:0]   den_reg, den_next;

    // Results and output register.
    logic [31:0] slope_reg, slope_next;
    logic        degen_reg, degen_next;
    logic [31:0] tmean_reg, tmean_next;
    logic [95:0] m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;
    logic        m_tvalid_reg, m_tvalid_next;

    // Sample memory, one word per slot: flux, temp, time from the top down.
    logic [95:0]   mem [WINDOW];
    logic [95:0]   rdata_reg;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic          we;

    // Shared units.
    logic               mul_en;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    div_req_t           div_req;
    logic [DIVW-1:0]    div_dividend;
    logic [DENW-1:0]    div_divisor;
    logic               div_busy;
    logic [DIVW-1:0]    div_q;

    // Helpers.
    logic            full;
    logic [AW:0]     slot_sum;
    logic [AW-1:0]   new_slot;
    logic [AW:0]     oldest_inc;
    logic [AW:0]     ptr_inc;
    logic            walk_last;
    logic [95:0]     op_a96, op_b96;
    logic [127:0]    term;
    logic [2:0]      limb_pos;
    logic [127:0]    acc_upd;
    logic            limb_last;
    logic [NUMW-1:0] num_mag_full;
    logic [DENW-1:0] num_mag;
    logic [SUMW-1:0] tsum_mag, fsum_mag;
    logic            negq;
    logic [31:0]     limit;
    logic            ovf;
    logic [31:0]     qsat;

    assign full       = (fill_reg == CW'(WINDOW));
    assign slot_sum   = (AW + 1)'(oldest_reg) + (AW + 1)'(fill_reg);
    assign new_slot   = (slot_sum >= (AW + 1)'(WINDOW)) ?
                        AW'(slot_sum - (AW + 1)'(WINDOW)) : AW'(slot_sum);
    assign oldest_inc = (AW + 1)'(oldest_reg) + (AW + 1)'(1);
    assign ptr_inc    = (AW + 1)'(ptr_reg) + (AW + 1)'(1);
    assign walk_last  = ((k_reg + CW'(1)) == fill_reg);

    // Operands of the four wide products.
    always_comb
    begin
        case (op_reg)
            OP_N_SXY:
            begin
                op_a96 = {{(96 - CW){1'b0}}, fill_reg};
                op_b96 = {{(96 - XYW){sxy_reg[XYW-1]}}, sxy_reg};
            end
            OP_SX_SY:
            begin
                op_a96 = {{(96 - SUMW){1'b0}}, sx_reg};
                op_b96 = {{(96 - SUMW){sy_reg[SUMW-1]}}, sy_reg};
            end
            OP_N_SXX:
            begin
                op_a96 = {{(96 - CW){1'b0}}, fill_reg};
                op_b96 = {{(96 - SQW){1'b0}}, sxx_reg};
            end
            default:
            begin
                op_a96 = {{(96 - SUMW){1'b0}}, sx_reg};
                op_b96 = {{(96 - SUMW){1'b0}}, sx_reg};
            end
        endcase
    end

    // Each limb product lands at 32 times the sum of its limb positions,
    // modulo 2^128; the true results are far narrower, so they come out exact.
    assign limb_pos  = 3'(li_reg) + 3'(lj_reg);
    assign term      = {{62{prod[65]}}, prod} << {limb_pos, 5'b0};
    assign acc_upd   = ((op_reg == OP_SX_SY) || (op_reg == OP_SX_SX)) ?
                       (acc_reg - term) : (acc_reg + term);
    assign limb_last = (li_reg == 2'd2) && (lj_reg == 2'd2);

    assign num_mag_full = num_reg[NUMW-1] ? (NUMW'(0) - num_reg) : num_reg;
    assign num_mag      = num_mag_full[DENW-1:0];
    assign tsum_mag     = tsum_reg[SUMW-1] ? (SUMW'(0) - tsum_reg) : tsum_reg;
    assign fsum_mag     = fsum_reg[SUMW-1] ? (SUMW'(0) - fsum_reg) : fsum_reg;

    // Slope saturation against the signed output range.
    assign negq  = num_reg[NUMW-1];
    assign limit = negq ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign ovf   = (|div_q[DIVW-1:32]) || (div_q[31:0] > limit);
    assign qsat  = ovf ? limit : div_q[31:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (s_tvalid) state_next = ST_OLD;
            ST_OLD:        state_next = ST_UPD;
            ST_UPD:        state_next = ST_RD;
            ST_RD:         state_next = ST_SQ;
            ST_SQ:         state_next = ST_XY;
            ST_XY:         state_next = ST_ACC;
            ST_ACC:        state_next = walk_last ? ST_WM_MUL : ST_RD;
            ST_WM_MUL:     state_next = ST_WM_ACC;
            ST_WM_ACC:
            begin
                if (limb_last && (op_reg == OP_SX_SX))
                begin
                    state_next = ST_SLOPE_GO;
                end
                else
                begin
                    state_next = ST_WM_MUL;
                end
            end
            ST_SLOPE_GO:   state_next = (den_reg == '0) ? ST_TMEAN_GO : ST_SLOPE_WAIT;
            ST_SLOPE_WAIT: if (!div_busy) state_next = ST_TMEAN_GO;
            ST_TMEAN_GO:   state_next = ST_TMEAN_WAIT;
            ST_TMEAN_WAIT: if (!div_busy) state_next = ST_FMEAN_GO;
            ST_FMEAN_GO:   state_next = ST_FMEAN_WAIT;
            ST_FMEAN_WAIT: if (!div_busy) state_next = ST_OUT;
            ST_OUT:        if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Unit controls.
    always_comb
    begin
        s_tready      = 1'b0;
        mul_en        = 1'b0;
        mul_a         = '0;
        mul_b         = '0;
        we            = 1'b0;
        waddr         = full ? oldest_reg : new_slot;
        raddr         = (state_reg == ST_OLD) ? oldest_reg : ptr_reg;
        div_req.start = 1'b0;
        div_req.steps = DIV_STEP_W'(SUMW);
        div_dividend  = {tsum_mag, {(DIVW - SUMW){1'b0}}};
        div_divisor   = DENW'(fill_reg);
        unique case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_UPD:   we = 1'b1;
            ST_SQ:
            begin
                mul_en = 1'b1;
                mul_a  = {1'b0, rdata_reg[31:0]};
                mul_b  = {1'b0, rdata_reg[31:0]};
            end
            ST_XY:
            begin
                mul_en = 1'b1;
                mul_a  = {1'b0, rdata_reg[31:0]};
                mul_b  = {rdata_reg[63], rdata_reg[63:32]};
            end
            ST_WM_MUL:
            begin
                mul_en = 1'b1;
                mul_a  = limb_sel(op_a96, li_reg);
                mul_b  = limb_sel(op_b96, lj_reg);
            end
            ST_SLOPE_GO:
            begin
                div_req.start = (den_reg != '0);
                div_req.steps = DIV_STEP_W'(DIVW);
                div_dividend  = {num_mag, 16'b0};
                div_divisor   = den_reg;
            end
            ST_TMEAN_GO:   div_req.start = 1'b1;
            ST_FMEAN_GO:
            begin
                div_req.start = 1'b1;
                div_dividend  = {fsum_mag, {(DIVW - SUMW){1'b0}}};
            end
            default:
            begin
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        smp_next      = smp_reg;
        fill_next     = fill_reg;
        oldest_next   = oldest_reg;
        ptr_next      = ptr_reg;
        k_next        = k_reg;
        tsum_next     = tsum_reg;
        fsum_next     = fsum_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        sxx_next      = sxx_reg;
        sxy_next      = sxy_reg;
        acc_next      = acc_reg;
        op_next       = op_reg;
        li_next       = li_reg;
        lj_next       = lj_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        slope_next    = slope_reg;
        degen_next    = degen_reg;
        tmean_next    = tmean_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    smp_next = s_tdata;
                end
            end
            ST_UPD:
            begin
                // A full window drops its oldest sample before the new one enters.
                tsum_next = tsum_reg + SUMW'(signed'(smp_reg[63:32]))
                            - (full ? SUMW'(signed'(rdata_reg[63:32])) : SUMW'(0));
                fsum_next = fsum_reg + SUMW'(signed'(smp_reg[95:64]))
                            - (full ? SUMW'(signed'(rdata_reg[95:64])) : SUMW'(0));
                if (full)
                begin
                    oldest_next = (oldest_inc == (AW + 1)'(WINDOW)) ?
                                  AW'(0) : AW'(oldest_inc);
                    ptr_next    = (oldest_inc == (AW + 1)'(WINDOW)) ?
                                  AW'(0) : AW'(oldest_inc);
                end
                else
                begin
                    fill_next = fill_reg + CW'(1);
                    ptr_next  = oldest_reg;
                end
                k_next   = '0;
                sx_next  = '0;
                sy_next  = '0;
                sxx_next = '0;
                sxy_next = '0;
            end
            ST_SQ:
            begin
                sx_next = sx_reg + SUMW'(rdata_reg[31:0]);
                sy_next = sy_reg + SUMW'(signed'(rdata_reg[63:32]));
            end
            ST_XY:
            begin
                sxx_next = sxx_reg + {{(SQW - 64){1'b0}}, prod[63:0]};
            end
            ST_ACC:
            begin
                sxy_next = sxy_reg + {{(XYW - 64){prod[63]}}, prod[63:0]};
                k_next   = k_reg + CW'(1);
                ptr_next = (ptr_inc == (AW + 1)'(WINDOW)) ? AW'(0) : AW'(ptr_inc);
                if (walk_last)
                begin
                    acc_next = '0;
                    op_next  = OP_N_SXY;
                    li_next  = 2'd0;
                    lj_next  = 2'd0;
                end
            end
            ST_WM_ACC:
            begin
                acc_next = acc_upd;
                if (lj_reg == 2'd2)
                begin
                    lj_next = 2'd0;
                    if (li_reg == 2'd2)
                    begin
                        li_next = 2'd0;
                        case (op_reg)
                            OP_N_SXY: op_next = OP_SX_SY;
                            OP_SX_SY:
                            begin
                                num_next = acc_upd[NUMW-1:0];
                                acc_next = '0;
                                op_next  = OP_N_SXX;
                            end
                            OP_N_SXX: op_next = OP_SX_SX;
                            default:  den_next = acc_upd[DENW-1:0];
                        endcase
                    end
                    else
                    begin
                        li_next = li_reg + 2'd1;
                    end
                end
                else
                begin
                    lj_next = lj_reg + 2'd1;
                end
            end
            ST_SLOPE_GO:
            begin
                // A zero denominator forces the slope to zero and raises the flag.
                slope_next = 32'd0;
                degen_next = (den_reg == '0);
            end
            ST_SLOPE_WAIT:
            begin
                if (!div_busy)
                begin
                    slope_next = negq ? (32'd0 - qsat) : qsat;
                end
            end
            ST_TMEAN_WAIT:
            begin
                if (!div_busy)
                begin
                    tmean_next = tsum_reg[SUMW-1] ? (32'd0 - div_q[31:0]) : div_q[31:0];
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tdata_next  = {fsum_reg[SUMW-1] ? (32'd0 - div_q[31:0]) : div_q[31:0],
                                     tmean_reg, slope_reg};
                    m_tuser_next  = degen_reg;
                    m_tvalid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            oldest_reg   <= '0;
            tsum_reg     <= '0;
            fsum_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            op_reg       <= OP_N_SXY;
            li_reg       <= '0;
            lj_reg       <= '0;
            k_reg        <= '0;
            ptr_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            oldest_reg   <= oldest_next;
            tsum_reg     <= tsum_next;
            fsum_reg     <= fsum_next;
            m_tvalid_reg <= m_tvalid_next;
            op_reg       <= op_next;
            li_reg       <= li_next;
            lj_reg       <= lj_next;
            k_reg        <= k_next;
            ptr_reg      <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg     <= smp_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        sxx_reg     <= sxx_next;
        sxy_reg     <= sxy_next;
        acc_reg     <= acc_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        slope_reg   <= slope_next;
        degen_reg   <= degen_next;
        tmean_reg   <= tmean_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // Sample memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= smp_reg;
        end
        rdata_reg <= mem[raddr];
    end

    swrs_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    swrs_div #(
        .DIVW (DIVW),
        .DENW (DENW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    // The held sample count never passes the window depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW))
        else $error("fill count exceeds window depth");

    // An accepted request keeps the sequencer busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one still in work");

    // A degenerate result always carries a zero slope.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[31:0] == 32'd0))
        else $error("degenerate flag with nonzero slope");

    // The divider only runs while the sequencer waits on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> ((state_reg == ST_SLOPE_WAIT) || (state_reg == ST_TMEAN_WAIT) ||
                      (state_reg == ST_FMEAN_WAIT)))
        else $error("divider busy outside a wait state");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/swrs_mul.sv =====
// ============================================================================
// swrs_mul - shared signed multiplier
// One 33 by 33 signed multiply with a registered product.
// ============================================================================
`default_nettype none

module swrs_mul (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [32:0] a,
    input  wire logic signed [32:0] b,
    output logic signed [65:0]      prod
);
    logic signed [65:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/core/swrs_div.sv =====
// ============================================================================
// swrs_div - iterative restoring divider
// Unsigned division, one quotient bit per cycle, dividend fed from its MSB.
// ============================================================================
`default_nettype none

module swrs_div #(
    parameter int DIVW = 88,
    parameter int DENW = 72
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire swrs_pkg::div_req_t  req,
    input  wire logic [DIVW-1:0]     dividend,
    input  wire logic [DENW-1:0]     divisor,
    output logic                     busy,
    output logic [DIVW-1:0]          quotient
);
    import swrs_pkg::*;

    logic                  busy_reg, busy_next;
    logic [DIV_STEP_W-1:0] cnt_reg, cnt_next;
    logic [DENW-1:0]       rem_reg, rem_next;
    logic [DENW-1:0]       dsr_reg, dsr_next;
    logic [DIVW-1:0]       dvd_reg, dvd_next;
    logic [DIVW-1:0]       q_reg, q_next;
    logic [DENW:0]         trial;
    logic [DENW:0]         diff;
    logic                  ge;

    assign trial = {rem_reg, dvd_reg[DIVW-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        dvd_next  = dvd_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            rem_next  = '0;
            dsr_next  = divisor;
            dvd_next  = dividend;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[DENW-1:0] : trial[DENW-1:0];
            dvd_next = {dvd_reg[DIVW-2:0], 1'b0};
            q_next   = {q_reg[DIVW-2:0], ge};
            cnt_next = cnt_reg - DIV_STEP_W'(1);
            if (cnt_reg == DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        dvd_reg <= dvd_next;
        q_reg   <= q_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// ===== test/swrs_checker.sv =====
// ============================================================================
// swrs_checker - result predictor and scoreboard for the sliding-window slope
// Watches both stream channels. It predicts slope, flag and means for every
// accepted sample, then compares each returned result with the oldest
// prediction.
// ============================================================================
`default_nettype none

module swrs_checker #(
    parameter int WINDOW = 5
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [95:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [95:0] m_tdata,
    input  wire logic        m_tuser,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] slope;
        logic        degenerate;
        logic [31:0] temp_mean;
        logic [31:0] flux_mean;
    } fit_t;

    logic [31:0]        held_time [WINDOW];
    logic signed [31:0] held_temp [WINDOW];
    logic signed [31:0] held_flux [WINDOW];
    longint             temp_sum;
    longint             flux_sum;
    int                 held_count;
    int                 oldest;
    fit_t               fit_queue [$];

    function automatic fit_t fit_sample(input logic [95:0] d);
        int                  slot;
        int                  s;
        logic signed [127:0] sx, sy, sxx, sxy, xv, yv, num, den, mag, quo, cap;
        logic signed [127:0] nn;
        logic                neg;
        fit_t                r;
        if (held_count < WINDOW) begin
            slot = (oldest + held_count) % WINDOW;
            held_count++;
        end
        else begin
            slot = oldest;
            temp_sum -= held_temp[slot];
            flux_sum -= held_flux[slot];
            oldest = (slot + 1) % WINDOW;
        end
        held_time[slot] = d[31:0];
        held_temp[slot] = d[63:32];
        held_flux[slot] = d[95:64];
        temp_sum += held_temp[slot];
        flux_sum += held_flux[slot];

        sx = 0; sy = 0; sxx = 0; sxy = 0;
        for (int k = 0; k < held_count; k++) begin
            s = (oldest + k) % WINDOW;
            xv = $signed({96'b0, held_time[s]});
            yv = 128'(held_temp[s]);
            sx += xv;
            sy += yv;
            sxx += xv * xv;
            sxy += xv * yv;
        end
        nn = 128'(held_count);
        num = nn * sxy - sx * sy;
        den = nn * sxx - sx * sx;
        if (den == 0) begin
            r.slope = 32'd0;
            r.degenerate = 1'b1;
        end
        else begin
            neg = num < 0;
            mag = neg ? -num : num;
            mag = mag <<< 16;
            quo = mag / den;
            cap = neg ? 128'sh8000_0000 : 128'sh7FFF_FFFF;
            if (quo > cap) quo = cap;
            r.slope = neg ? 32'(-quo) : 32'(quo);
            r.degenerate = 1'b0;
        end
        r.temp_mean = 32'(temp_sum / longint'(held_count));
        r.flux_mean = 32'(flux_sum / longint'(held_count));
        return r;
    endfunction

    assign pending = fit_queue.size();

    always @(posedge clk or negedge rst_n) begin
        fit_t want;
        if (!rst_n) begin
            temp_sum <= 0;
            flux_sum <= 0;
            held_count <= 0;
            oldest <= 0;
            errors <= 0;
            fit_queue.delete();
        end
        else begin
            if (s_tvalid && s_tready)
                fit_queue.push_back(fit_sample(s_tdata));
            if (m_tvalid && m_tready) begin
                if (fit_queue.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected result slope=%h mean=%h/%h", $realtime,
                                 m_tdata[31:0], m_tdata[63:32], m_tdata[95:64]);
                    errors <= errors + 1;
                end
                else begin
                    want = fit_queue.pop_front();
                    if (want.slope !== m_tdata[31:0] || want.degenerate !== m_tuser ||
                        want.temp_mean !== m_tdata[63:32] ||
                        want.flux_mean !== m_tdata[95:64]) begin
                        if (errors < 10)
                            $display("%0t: mismatch expected %h/%b/%h/%h got %h/%b/%h/%h",
                                     $realtime, want.slope, want.degenerate,
                                     want.temp_mean, want.flux_mean, m_tdata[31:0],
                                     m_tuser, m_tdata[63:32], m_tdata[95:64]);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// ============================================================================
// tb_top - stimulus and verdict for the sliding-window slope block
// Drives directed corner samples and then random sample streams, with random
// gaps on both channels; a separate checker predicts and compares results.
// ============================================================================
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;     // sample_time, temp_sample, flux_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;     // temp_slope, temp_mean, flux_mean
    logic        m_tuser;     // slope_degenerate
    int          errors;
    int          pending;
    int          idle_cycles;
    logic        sender_burst;
    logic        receiver_burst;
    logic [31:0] clock_now;

    sliding_window_regression_slope_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    swrs_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sends one sample request. A gap of zero keeps tvalid high across
    // back-to-back requests, so it is never lowered and raised in one step.
    task automatic send_sample(input logic [31:0] t, input logic [31:0] y,
                               input logic [31:0] f);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {f, y, t};
        do @(posedge clk); while (!s_tready);
    endtask

    // The result side stalls at random too, with burst stretches of no stall.
    initial
    begin
        int gap;
        m_tready <= 1'b0;
        receiver_burst = 1'b0;
        @(posedge rst_n);
        forever begin
            gap = receiver_burst ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            if ($urandom_range(0, 29) == 0) receiver_burst = !receiver_burst;
        end
    end

    // The watchdog counts cycles with no request accepted on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        int          run_len;
        logic [31:0] step;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        idle_cycles  = 0;
        sender_burst = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first sample alone gives a zero denominator.
        send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        // Equal timestamps keep the fit degenerate.
        send_sample(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF);
        // One tick apart with an extreme temperature swing saturates upward.
        send_sample(32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // The window is now full; the next samples push the oldest out.
        send_sample(32'h0000_0002, 32'h8000_0000, 32'h8000_0000);
        send_sample(32'h0000_0003, 32'h8000_0000, 32'h8000_0000);
        send_sample(32'h0000_0004, 32'h8000_0000, 32'h8000_0000);
        send_sample(32'h0000_0005, 32'h8000_0000, 32'h8000_0000);
        send_sample(32'h0000_0006, 32'h7FFF_FFFF, 32'h0000_0000);
        // Extreme timestamps spread across the full unsigned range.
        send_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_sample(32'h0000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
        send_sample(32'hFFFF_FFFF, 32'h8000_0000, 32'hEDCB_A988);
        send_sample(32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFE);
        send_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0003);
        // All timestamps equal over a full window at the top of the range.
        repeat (5) send_sample(32'hFFFF_FFFF, $urandom, $urandom);
        // A clean ramp, one second per sample.
        for (int i = 0; i < 5; i++)
            send_sample(32'h0010_0000 + i * 32'h0001_0000, i * 32'h0002_0000, -i);

        // Let every outstanding result drain before the random part. Wait on the
        // clock first, so the checker has queued the last accepted request.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        // Random part: mostly rising time series with random steps and
        // readings, with fully random samples and repeated timestamps mixed in.
        clock_now = $urandom;
        for (int n = 0; n < 450; n += run_len) begin
            run_len = $urandom_range(3, 20);
            if ($urandom_range(0, 3) == 0) sender_burst = !sender_burst;
            for (int k = 0; k < run_len; k++) begin
                case ($urandom_range(0, 9))
                    0, 1:    send_sample($urandom, $urandom, $urandom);
                    2:       send_sample(clock_now, $urandom, $urandom);
                    default: begin
                        step = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 32'h0004_0000)
                                                           : $urandom;
                        clock_now = clock_now + step;
                        send_sample(clock_now, ($urandom_range(0, 1) != 0)
                                    ? $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000
                                    : $urandom, $urandom);
                    end
                endcase
            end
            if (n > 200 && n < 230) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/swrs_pkg.sv
rtl/core/swrs_mul.sv
rtl/core/swrs_div.sv
rtl/core/sliding_window_regression_slope_top.sv
test/swrs_checker.sv
test/tb_top.sv
